// ----- design/ocp_pkg.sv -----
// shared constants, tables and helpers for the orbit camera position block
package ocp_pkg;

    // angle conversion: phase = floor((deg*256 + 45) / 90), biased positive for the divider
    localparam int DIV_W    = 25;
    localparam int QUOT_W   = 18;
    localparam int REM_W    = 7;
    localparam int DIVISOR  = 90;
    localparam int DEG_BIAS = 11796525;   // 45 + 90 * 2^17

    // cordic datapath
    localparam int CORD_W      = 34;
    localparam int ATAN_W      = 32;
    localparam int CORDIC_GAIN = 652032874;
    localparam int MAX_STEPS   = 24;

    // serial multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // limits
    localparam int PITCH_LIMIT  = 15341;
    localparam int RADIUS_LOW   = 512;
    localparam int RADIUS_HIGH  = 20480;
    localparam int RADIUS_RESET = 2560;

    localparam int RADIUS_W = 15;
    localparam int COORD_W  = 24;
    localparam int DEG_W    = 16;
    localparam int PHASE_W  = 16;

    // input kinds
    localparam logic [1:0] KIND_SET = 2'd0;
    localparam logic [1:0] KIND_ADD = 2'd1;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z = 2'd3;

    // atan(2^-i) with one turn = 2^32
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // biased dividend for the angle conversion
    function automatic logic [DIV_W-1:0] deg_to_num(input logic [DEG_W-1:0] d);
        logic [DIV_W:0] s;
        s = {{2{d[DEG_W-1]}}, d, 8'b0} + (DIV_W+1)'(DEG_BIAS);
        return s[DIV_W-1:0];
    endfunction

endpackage

// ----- design/ocp_if.sv -----
// handshake channels of the orbit camera position block
interface ocp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] yaw_deg;
    logic [15:0] pitch_deg;
    modport source(output valid, kind, yaw_deg, pitch_deg, input ready);
    modport sink(input valid, kind, yaw_deg, pitch_deg, output ready);
endinterface

interface ocp_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] pos_z;
    modport source(output valid, pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- design/orbit_camera_position.sv -----
// Orbit camera position: keeps yaw and pitch and returns target + radius * (cos p sin y,
// sin p, cos p cos y) for every input word. One word is worked at a time: two bit-serial
// divisions convert the angles, one shared cordic runs CORDIC_STEPS rotations for pitch
// and again for yaw, and one shared shift-add multiplier forms each of four products in
// turn. A finished word sits in the output register while the next input word is accepted.
module orbit_camera_position import ocp_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ocp_in_if.sink               i_in,
    ocp_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_P, ST_DIV_Y, ST_SIN_P, ST_SIN_Y,
        ST_MUL_C, ST_MUL_Y, ST_MUL_X, ST_MUL_Z, ST_OUT
    } t_state;

    t_state                    r_state;
    logic [RADIUS_W-1:0]       r_radius;
    logic [COORD_W-1:0]        r_tx, r_ty, r_tz;
    logic [PHASE_W-1:0]        r_yaw;
    logic [PHASE_W-1:0]        r_pitch;
    logic [1:0]                r_kind;
    logic [DEG_W-1:0]          r_yaw_deg;
    logic [QUOT_W-1:0]         r_dp;
    logic signed [CORD_W-1:0]  r_sp, r_cp, r_sy, r_cy;
    logic [30:0]               r_c;
    logic [24:0]               r_py, r_px, r_pz;
    logic                      r_out_valid;
    logic [COORD_W-1:0]        r_pos_x, r_pos_y, r_pos_z;

    logic                      r_div_start;
    logic [DIV_W-1:0]          r_div_num;
    logic                      r_cor_start;
    logic [PHASE_W-1:0]        r_cor_phase;
    logic                      r_mul_start;
    logic signed [MUL_A_W-1:0] r_mul_a;
    logic signed [MUL_B_W-1:0] r_mul_b;

    logic                      div_done;
    logic [QUOT_W-1:0]         div_quot;
    logic                      cor_done;
    logic signed [CORD_W-1:0]  cor_sin, cor_cos;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;

    logic [RADIUS_W-1:0]       n_radius;
    logic [PHASE_W-1:0]        n_dy;
    logic signed [18:0]        n_psum;
    logic [PHASE_W-1:0]        n_pclamp;
    logic [PHASE_W-1:0]        n_yaw;
    logic [PHASE_W-1:0]        n_pitch;
    logic [PROD_W-1:0]         n_rnd30;
    logic [PROD_W-1:0]         n_rnd45;
    logic [24:0]               n_pz;

    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] t,
                                                   input logic [24:0] d);
        logic signed [25:0] s;
        s = $signed({{2{t[COORD_W-1]}}, t}) + $signed({d[24], d});
        if (s > 26'sd8388607) begin
            return 24'h7FFFFF;
        end else if (s < -26'sd8388608) begin
            return 24'h800000;
        end else begin
            return s[COORD_W-1:0];
        end
    endfunction

    ocp_div90 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ocp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_phase (r_cor_phase),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    ocp_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // radius writes saturate to the legal range
    always_comb begin
        priority if (i_cfg_data[RADIUS_W-1:0] < RADIUS_W'(RADIUS_LOW)) begin
            n_radius = RADIUS_W'(RADIUS_LOW);
        end else if (i_cfg_data[RADIUS_W-1:0] > RADIUS_W'(RADIUS_HIGH)) begin
            n_radius = RADIUS_W'(RADIUS_HIGH);
        end else begin
            n_radius = i_cfg_data[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(RADIUS_RESET);
            r_tx     <= '0;
            r_ty     <= '0;
            r_tz     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:   r_radius <= n_radius;
                REG_TARGET_X: r_tx     <= i_cfg_data;
                REG_TARGET_Y: r_ty     <= i_cfg_data;
                REG_TARGET_Z: r_tz     <= i_cfg_data;
            endcase
        end
    end

    // angle update, quotient carries a bias of 2^17
    always_comb begin
        n_dy = div_quot[PHASE_W-1:0];
        if (r_kind == KIND_ADD) begin
            n_psum = 19'($signed(r_pitch)) + 19'($signed({~r_dp[QUOT_W-1], r_dp[QUOT_W-2:0]}));
        end else begin
            n_psum = 19'($signed({~r_dp[QUOT_W-1], r_dp[QUOT_W-2:0]}));
        end
        priority if (n_psum > 19'(PITCH_LIMIT)) begin
            n_pclamp = PHASE_W'(PITCH_LIMIT);
        end else if (n_psum < -19'(PITCH_LIMIT)) begin
            n_pclamp = PHASE_W'(-PITCH_LIMIT);
        end else begin
            n_pclamp = n_psum[PHASE_W-1:0];
        end
        priority if (r_kind == KIND_SET) begin
            n_yaw   = n_dy;
            n_pitch = n_pclamp;
        end else if (r_kind == KIND_ADD) begin
            n_yaw   = r_yaw + n_dy;
            n_pitch = n_pclamp;
        end else begin
            n_yaw   = r_yaw;
            n_pitch = r_pitch;
        end
    end

    assign n_rnd30 = mul_prod + (PROD_W'(1) << 29);
    assign n_rnd45 = mul_prod + (PROD_W'(1) << 44);
    assign n_pz    = {{4{n_rnd45[PROD_W-1]}}, n_rnd45[PROD_W-1:45]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_yaw       <= PHASE_W'(32768);
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            r_mul_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == ST_IDLE && i_in.valid)
                           || (r_state == ST_DIV_P && div_done);
            r_cor_start <= (r_state == ST_DIV_Y && div_done)
                           || (r_state == ST_SIN_P && cor_done);
            r_mul_start <= (r_state == ST_SIN_Y && cor_done)
                           || (mul_done && (r_state == ST_MUL_C || r_state == ST_MUL_Y
                                            || r_state == ST_MUL_X));
            // a held word stays until taken, a finished one is loaded in ST_OUT
            r_out_valid <= (r_state == ST_OUT) || (r_out_valid && !o_out.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_kind      <= i_in.kind;
                        r_yaw_deg   <= i_in.yaw_deg;
                        r_div_num   <= deg_to_num(i_in.pitch_deg);
                        r_state     <= ST_DIV_P;
                    end
                end
                ST_DIV_P: begin
                    if (div_done) begin
                        r_dp        <= div_quot;
                        r_div_num   <= deg_to_num(r_yaw_deg);
                        r_state     <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y: begin
                    if (div_done) begin
                        r_yaw       <= n_yaw;
                        r_pitch     <= n_pitch;
                        r_cor_phase <= n_pitch;
                        r_state     <= ST_SIN_P;
                    end
                end
                ST_SIN_P: begin
                    if (cor_done) begin
                        r_sp        <= cor_sin;
                        r_cp        <= cor_cos;
                        r_cor_phase <= r_yaw;
                        r_state     <= ST_SIN_Y;
                    end
                end
                ST_SIN_Y: begin
                    if (cor_done) begin
                        r_sy        <= cor_sin;
                        r_cy        <= cor_cos;
                        r_mul_a     <= r_cp;
                        r_mul_b     <= {{(MUL_B_W-RADIUS_W){1'b0}}, r_radius};
                        r_state     <= ST_MUL_C;
                    end
                end
                ST_MUL_C: begin
                    if (mul_done) begin
                        r_c         <= mul_prod[45:15];
                        r_mul_a     <= r_sp;
                        r_mul_b     <= {{(MUL_B_W-RADIUS_W){1'b0}}, r_radius};
                        r_state     <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y: begin
                    if (mul_done) begin
                        r_py        <= n_rnd30[54:30];
                        r_mul_a     <= r_sy;
                        r_mul_b     <= {r_c[30], r_c};
                        r_state     <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    if (mul_done) begin
                        r_px        <= {{4{n_rnd45[PROD_W-1]}}, n_rnd45[PROD_W-1:45]};
                        r_mul_a     <= r_cy;
                        r_mul_b     <= {r_c[30], r_c};
                        r_state     <= ST_MUL_Z;
                    end
                end
                ST_MUL_Z: begin
                    if (mul_done) begin
                        r_pz    <= n_pz;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_pos_x     <= sat_add(r_tx, r_px);
                        r_pos_y     <= sat_add(r_ty, r_py);
                        r_pos_z     <= sat_add(r_tz, r_pz);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready  = r_state == ST_IDLE;
    assign o_out.valid = r_out_valid;
    assign o_out.pos_x = r_pos_x;
    assign o_out.pos_y = r_pos_y;
    assign o_out.pos_z = r_pos_z;
endmodule

// ----- design/ocp_div90.sv -----
// bit-serial restoring divider by the constant 90
module ocp_div90 import ocp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);
    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DIV_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [REM_W:0]    n_trial;
    logic              n_ge;

    assign n_trial = {r_rem, r_num[DIV_W-1]};
    assign n_ge    = n_trial >= (REM_W+1)'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'(DIV_W-1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? REM_W'(n_trial - (REM_W+1)'(DIVISOR)) : n_trial[REM_W-1:0];
                r_num  <= {r_num[DIV_W-2:0], 1'b0};
                r_quot <= {r_quot[QUOT_W-2:0], n_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- design/ocp_cordic.sv -----
// iterative cordic, one rotation per cycle, sine and cosine of a 16-bit phase
module ocp_cordic import ocp_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic                     o_done,
    output logic signed [CORD_W-1:0] o_sin,
    output logic signed [CORD_W-1:0] o_cos
);
    localparam int IW = $clog2(STEPS);
    localparam logic signed [CORD_W-1:0] QTR  = CORD_W'(64'sd1073741824);
    localparam logic signed [CORD_W-1:0] HALF = CORD_W'(64'sd2147483648);

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_i;
    logic                     r_neg;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [CORD_W-1:0] r_z;
    logic signed [CORD_W-1:0] n_z0;
    logic signed [CORD_W-1:0] n_z1;
    logic                     n_neg;
    logic signed [CORD_W-1:0] n_xs;
    logic signed [CORD_W-1:0] n_ys;
    logic signed [CORD_W-1:0] n_at;

    always_comb begin
        n_z0  = {{2{i_phase[PHASE_W-1]}}, i_phase, 16'b0};
        n_z1  = n_z0;
        n_neg = 1'b0;
        // fold the outer half turn onto the inner one, negating both outputs
        priority if (n_z0 > QTR) begin
            n_z1  = n_z0 - HALF;
            n_neg = 1'b1;
        end else if (n_z0 < -QTR) begin
            n_z1  = n_z0 + HALF;
            n_neg = 1'b1;
        end else begin
            n_z1 = n_z0;
        end
    end

    assign n_xs = r_x >>> r_i;
    assign n_ys = r_y >>> r_i;
    assign n_at = CORD_W'(atan_turn(5'(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == IW'(STEPS-1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= CORD_W'(CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= n_z1;
                r_neg  <= n_neg;
            end else if (r_busy) begin
                if (!r_z[CORD_W-1]) begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_at;
                end else begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_at;
                end
                r_i <= r_i + IW'(1);
                if (r_i == IW'(STEPS-1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_cos  = r_neg ? -r_x : r_x;
endmodule

// ----- design/ocp_smul.sv -----
// shift-add signed multiplier, one multiplier bit per cycle
module ocp_smul import ocp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic                      o_done,
    output logic signed [PROD_W-1:0]  o_prod
);
    localparam int HI_W = MUL_A_W + 2;
    localparam int CW   = $clog2(MUL_B_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic signed [MUL_A_W-1:0] r_a;
    logic signed [HI_W-1:0]    r_hi;
    logic [MUL_B_W-1:0]        r_lo;
    logic signed [HI_W-1:0]    n_add;
    logic signed [HI_W-1:0]    n_sum;
    logic                      n_last;

    assign n_last = r_cnt == CW'(MUL_B_W-1);
    assign n_add  = r_lo[0] ? HI_W'(r_a) : '0;
    // the sign bit of the multiplier carries negative weight
    assign n_sum  = n_last ? r_hi - n_add : r_hi + n_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && n_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                r_hi  <= n_sum >>> 1;
                r_lo  <= {n_sum[0], r_lo[MUL_B_W-1:1]};
                r_cnt <= r_cnt + CW'(1);
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[PROD_W-MUL_B_W-1:0], r_lo};
endmodule

// ----- design/ocp_checker.sv -----
// port-level checks for the orbit camera position block, bound to the top level
module ocp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [71:0] i_out_word
);
    // a word held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("output word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    // a new result only appears at the end of a busy stretch
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");
endmodule

bind orbit_camera_position ocp_checker u_ocp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  ({o_out.pos_x, o_out.pos_y, o_out.pos_z})
);

// ----- dv/orbit_camera_position_test.sv -----
// self-checking testbench for the orbit camera position block
module orbit_camera_position_test;
    import ocp_pkg::*;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } position_t;

    localparam int NUM_ROTATIONS = 16;
    localparam longint ATAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam logic [1:0] KIND_REFRESH = 2'd2;
    localparam logic [1:0] KIND_SPARE   = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COORD_W-1:0]   i_cfg_data;

    ocp_in_if  in_if();
    ocp_out_if out_if();

    orbit_camera_position dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [14:0] cam_radius;
    logic [23:0] cam_target [3];
    logic [15:0] cam_yaw;
    logic [15:0] cam_pitch;

    position_t pos_due_q[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        words_sent;
    int        words_checked;
    int        mismatches;

    function automatic longint phase_of_deg(input logic [15:0] d);
        longint n;
        n = longint'($signed(d)) * 256 + 45;
        if (n >= 0)
            return n / 90;
        return -((-n + 89) / 90);
    endfunction

    function automatic void sin_cos(input logic [15:0] ph, output longint s, output longint c);
        longint z, x, y, t;
        bit     flip;
        z = longint'(ph) * 65536;
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        if (z >= (64'sd1 <<< 31))
            z -= 64'sd1 <<< 32;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < NUM_ROTATIONS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_STEP[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_STEP[i];
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [23:0] clip24(input longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    function automatic longint clamp_pitch(input longint p);
        if (p > PITCH_LIMIT)
            return PITCH_LIMIT;
        if (p < -PITCH_LIMIT)
            return -PITCH_LIMIT;
        return p;
    endfunction

    // advance the angle state and work out the next camera position
    function automatic position_t predict_position(input logic [1:0] kind,
                                                   input logic [15:0] yaw_d,
                                                   input logic [15:0] pitch_d);
        longint    dy, dp, p, sp, cp, sy, cy, r, c;
        position_t res;
        dy = phase_of_deg(yaw_d);
        dp = phase_of_deg(pitch_d);
        p = longint'($signed(cam_pitch));
        if (kind == KIND_SET) begin
            cam_yaw = dy[15:0];
            p = clamp_pitch(dp);
        end else if (kind == KIND_ADD) begin
            cam_yaw = cam_yaw + dy[15:0];
            p = clamp_pitch(p + dp);
        end
        cam_pitch = p[15:0];
        sin_cos(cam_pitch, sp, cp);
        sin_cos(cam_yaw, sy, cy);
        r = longint'(cam_radius);
        c = (r * cp) >>> 15;
        res.x = clip24(longint'($signed(cam_target[0]))
                       + ((c * sy + (64'sd1 <<< 44)) >>> 45));
        res.y = clip24(longint'($signed(cam_target[1]))
                       + ((r * sp + (64'sd1 <<< 29)) >>> 30));
        res.z = clip24(longint'($signed(cam_target[2]))
                       + ((c * cy + (64'sd1 <<< 44)) >>> 45));
        return res;
    endfunction

    // receive side: random stalls and compare against the oldest expectation
    always @(posedge i_clk) begin
        position_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pos_due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: x=%0d y=%0d z=%0d", $signed(out_if.pos_x),
                             $signed(out_if.pos_y), $signed(out_if.pos_z));
            end else begin
                want = pos_due_q.pop_front();
                words_checked++;
                if (want.x !== out_if.pos_x || want.y !== out_if.pos_y
                        || want.z !== out_if.pos_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("position mismatch: expected (%0d %0d %0d) got (%0d %0d %0d)",
                                 $signed(want.x), $signed(want.y), $signed(want.z),
                                 $signed(out_if.pos_x), $signed(out_if.pos_y),
                                 $signed(out_if.pos_z));
                end
            end
        end
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [1:0] kind, input logic [15:0] yaw_d,
                             input logic [15:0] pitch_d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.yaw_deg   <= yaw_d;
        in_if.pitch_deg <= pitch_d;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        pos_due_q.push_back(predict_position(kind, yaw_d, pitch_d));
        words_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pos_due_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        logic [14:0] r;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_RADIUS) begin
            r = value[14:0];
            if (r < RADIUS_LOW)
                r = 15'(RADIUS_LOW);
            if (r > RADIUS_HIGH)
                r = 15'(RADIUS_HIGH);
            cam_radius = r;
        end else begin
            cam_target[idx - 1] = value;
        end
    endtask

    task automatic test_angle_extremes();
        send_word(KIND_REFRESH, 16'd0, 16'd0);
        send_word(KIND_SET, 16'd0, 16'd0);
        send_word(KIND_SET, 16'sd23040, 16'sd5760);
        send_word(KIND_SET, -16'sd23040, -16'sd5760);
        send_word(KIND_SET, 16'sd5760, 16'sd23040);      // pitch clamps high
        send_word(KIND_SET, -16'sd5760, -16'sd23040);    // pitch clamps low
        send_word(KIND_SET, 16'h7FFF, 16'h8000);
        send_word(KIND_SET, 16'h8000, 16'h7FFF);
        send_word(KIND_SET, 16'hFFFF, 16'hFFFF);
        send_word(KIND_SPARE, 16'h1234, 16'h4321);       // spare kind only refreshes
    endtask

    task automatic test_accumulate();
        send_word(KIND_SET, 16'd0, 16'd0);
        repeat (4) send_word(KIND_ADD, 16'sd9000, 16'sd2000);   // yaw wraps, pitch saturates
        repeat (4) send_word(KIND_ADD, -16'sd23040, -16'sd3000);
        send_word(KIND_ADD, 16'h7FFF, 16'h7FFF);
        send_word(KIND_ADD, 16'h8000, 16'h8000);
        send_word(KIND_REFRESH, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_RADIUS, 24'd0);
        write_reg(REG_TARGET_X, 24'h7FFFFF);
        write_reg(REG_TARGET_Y, 24'h800000);
        write_reg(REG_TARGET_Z, 24'h7FFFF0);
        send_word(KIND_SET, 16'sd5760, 16'sd3000);
        send_word(KIND_SET, -16'sd5760, -16'sd3000);
        wait_idle();
        write_reg(REG_RADIUS, 24'hFFFFFF);             // upper bits dropped, then clamped
        write_reg(REG_TARGET_X, 24'h800000);
        write_reg(REG_TARGET_Y, 24'h7FFFFF);
        write_reg(REG_TARGET_Z, 24'h800010);
        send_word(KIND_SET, -16'sd5760, 16'sd5760);
        send_word(KIND_SET, 16'sd11520, -16'sd5760);
        wait_idle();
        write_reg(REG_RADIUS, 24'h008100);             // masks to a value below the floor
        send_word(KIND_REFRESH, 16'd0, 16'd0);
        wait_idle();
        write_reg(REG_RADIUS, 24'h005000);
        send_word(KIND_REFRESH, 16'd0, 16'd0);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(3))
            0:       return 16'($urandom());
            1:       return 16'($signed($urandom_range(46080)) - 23040);
            2:       return 16'($signed($urandom_range(1200)) - 600);
            default: return $urandom_range(1) ? 16'sd23040 : -16'sd23040;
        endcase
    endfunction

    task automatic test_random_walk(input int count);
        logic [1:0] kind;
        int         k;
        wait_idle();
        write_reg(REG_RADIUS, 24'($urandom_range(RADIUS_HIGH + 1000, 0)));
        for (int i = 1; i <= 3; i++) begin
            k = $urandom_range(9);
            write_reg(CFG_IDX_W'(i),
                      k == 0 ? 24'($urandom()) : 24'($signed($urandom_range(200000)) - 100000));
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(19);
            kind = (k < 6) ? KIND_SET : (k < 16) ? KIND_ADD : (k < 19) ? KIND_REFRESH : KIND_SPARE;
            send_word(kind, pick_angle(), pick_angle());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_RADIUS;
        i_cfg_data      <= '0;
        in_if.valid     <= 1'b0;
        in_if.kind      <= KIND_SET;
        in_if.yaw_deg   <= '0;
        in_if.pitch_deg <= '0;
        cam_radius    = 15'(RADIUS_RESET);
        cam_target[0] = '0;
        cam_target[1] = '0;
        cam_target[2] = '0;
        cam_yaw       = 16'd32768;
        cam_pitch     = '0;
        send_idle_pct = 31;
        recv_idle_pct = 73;
        words_sent    = 0;
        words_checked = 0;
        mismatches    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_angle_extremes();
        test_accumulate();
        test_register_extremes();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 31 : 0;
            repeat (2) test_random_walk(275);
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        $display("sent %0d words over set, add and refresh kinds, checked %0d positions",
                 words_sent, words_checked);
        $display("register extremes, saturation and three stall profiles covered, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pos_due_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout with %0d positions outstanding", pos_due_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ocp_pkg.sv
design/ocp_if.sv
design/ocp_div90.sv
design/ocp_cordic.sv
design/ocp_smul.sv
design/orbit_camera_position.sv
design/ocp_checker.sv
dv/orbit_camera_position_test.sv
